FILE: design/npb_pkg.sv
`timescale 1ns / 1ps
package npb_pkg;

  localparam int GAIN_COUNT = 8;
  localparam int COMP_SLOTS = 4;
  localparam int QTY_COUNT  = 6;

  // configuration register indexes
  localparam logic [2:0] REG_STATE_SIZE  = 3'd0;
  localparam logic [2:0] REG_COMP_COUNT  = 3'd1;
  localparam logic [2:0] REG_COMP_ENDS   = 3'd2;
  localparam logic [2:0] REG_INV_SCALE_0 = 3'd3;
  localparam logic [2:0] REG_INV_SCALE_1 = 3'd4;
  localparam logic [2:0] REG_INV_SCALE_2 = 3'd5;
  localparam logic [2:0] REG_INV_SCALE_3 = 3'd6;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_ROW  = 1'b1;

  localparam logic [1:0] STS_OK  = 2'd0;
  localparam logic [1:0] STS_SAT = 2'd1;
  localparam logic [1:0] STS_CFG = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCALE,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic               action;
    logic [2:0]         row;
    logic signed [31:0] theta_value;
    logic signed [31:0] gain_0;
    logic signed [31:0] gain_1;
    logic signed [31:0] gain_2;
    logic signed [31:0] gain_3;
    logic signed [31:0] gain_4;
    logic signed [31:0] gain_5;
    logic signed [31:0] gain_6;
    logic signed [31:0] gain_7;
    logic               step_end;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         row_out;
    logic signed [31:0] standardized;
    logic signed [31:0] baseline;
    logic signed [31:0] basis_0;
    logic signed [31:0] basis_1;
    logic signed [31:0] basis_2;
    logic signed [31:0] basis_3;
    logic               step_last;
    logic [1:0]         status;
  } out_word_t;

  // {saturated, value}
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] res;
    if (v > 64'sd2147483647) begin
      res = {1'b1, 32'h7fffffff};
    end else if (v < -64'sd2147483648) begin
      res = {1'b1, 32'h80000000};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

endpackage

FILE: design/noncentered_path_basis.sv
`timescale 1ns / 1ps
// Row items go through acceptance and then the multiply state, in which eight lane
// multipliers run the six row products (state, baseline, four basis columns) one
// product kind per cycle with the lane sum folded in the cycle after, then the
// reciprocal-scale multiply and a finish state that writes the fresh bank and loads
// the output register, waiting there while a held result is stalled. A row whose
// configuration is inconsistent goes straight to finish. Load items return nothing.
// One item is worked on at a time; a finished word may wait in the output register while the next item is accepted.
module noncentered_path_basis #(
  parameter int MAX_STATE      = 8,
  parameter int MAX_COMPONENTS = 4,
  parameter int FRAC_BITS      = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  npb_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output npb_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int LANES = (MAX_STATE < npb_pkg::GAIN_COUNT) ? MAX_STATE : npb_pkg::GAIN_COUNT;
  localparam int RW    = (MAX_STATE > 1) ? $clog2(MAX_STATE) : 1;
  localparam int PW    = 64 - FRAC_BITS;
  localparam int AW    = 67 - FRAC_BITS;

  npb_pkg::state_t state_r, state_nxt;

  logic [3:0]  state_size_r;
  logic [2:0]  comp_count_r;
  logic [15:0] comp_ends_r;
  logic [31:0] inv_r [npb_pkg::COMP_SLOTS];

  logic signed [31:0] st_r [2][MAX_STATE];
  logic signed [31:0] bl_r [2][MAX_STATE];
  logic signed [31:0] bs_r [2][MAX_STATE][MAX_COMPONENTS];
  logic               sel_r;

  logic [2:0]         row_r;
  logic signed [31:0] theta_r;
  logic signed [31:0] g_r [npb_pkg::GAIN_COUNT];
  logic               end_r;
  logic [1:0]         comp_r;
  logic               bad_r;
  logic               sat_r;
  logic [2:0]         cnt_r;
  logic signed [AW-1:0] acc_r [npb_pkg::QTY_COUNT];
  logic signed [63:0]   scl_r;

  logic               out_valid_r;
  npb_pkg::out_word_t out_r;

  logic signed [31:0] opnd [LANES];
  logic               lane_en [LANES];
  logic signed [PW-1:0] prod [LANES];
  logic signed [AW-1:0] lane_sum;

  logic       accept;
  logic       fin_go;
  logic       cfg_bad;
  logic [1:0] cfg_comp;

  logic [32:0] innov_s;
  logic signed [63:0] scl_nxt;

  logic [32:0] stdz_s;
  logic [32:0] base_s;
  logic [32:0] bas_s [npb_pkg::COMP_SLOTS];
  logic        fin_sat;
  npb_pkg::out_word_t fin_w;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // component lookup and consistency check
  always_comb begin
    logic signed [4:0] prev;
    logic              found;
    prev     = -5'sd1;
    found    = 1'b0;
    cfg_bad  = 1'b0;
    cfg_comp = '0;
    if (state_size_r < 4'd1 || 32'(state_size_r) > MAX_STATE) cfg_bad = 1'b1;
    if (comp_count_r < 3'd1 || 32'(comp_count_r) > MAX_COMPONENTS) cfg_bad = 1'b1;
    if ({1'b0, in_data.row} >= state_size_r) cfg_bad = 1'b1;
    for (int j = 0; j < npb_pkg::COMP_SLOTS; j++) begin
      if (3'(j) < comp_count_r) begin
        if ($signed({1'b0, comp_ends_r[4*j +: 4]}) <= prev) cfg_bad = 1'b1;
        if (!found && {1'b0, in_data.row} <= comp_ends_r[4*j +: 4]) begin
          found    = 1'b1;
          cfg_comp = 2'(j);
        end
        prev = $signed({1'b0, comp_ends_r[4*j +: 4]});
      end
    end
    if (prev != $signed({1'b0, state_size_r}) - 5'sd1) cfg_bad = 1'b1;
  end

  // lane operands: one product kind per cycle
  always_comb begin
    for (int k = 0; k < LANES; k++) begin
      lane_en[k] = 4'(k) < state_size_r;
      opnd[k]    = '0;
      if (cnt_r == 3'd0) begin
        opnd[k] = st_r[sel_r][k];
      end else if (cnt_r == 3'd1) begin
        opnd[k] = bl_r[sel_r][k];
      end
      for (int j = 0; j < MAX_COMPONENTS; j++) begin
        if (cnt_r == 3'(j + 2)) opnd[k] = bs_r[sel_r][k][j];
      end
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    npb_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
      .clk    (clk),
      .en     (lane_en[k]),
      .gain   (g_r[k]),
      .opnd   (opnd[k]),
      .prod_r (prod[k])
    );
  end

  npb_merge #(.LANES(LANES), .FRAC_BITS(FRAC_BITS)) u_merge (
    .prod (prod),
    .sum  (lane_sum)
  );

  always_comb begin
    innov_s = npb_pkg::sat32(64'(theta_r) - 64'(acc_r[0]));
    scl_nxt = $signed(innov_s[31:0]) * $signed({1'b0, inv_r[comp_r]});
  end

  always_comb begin
    logic [32:0] t;
    stdz_s  = npb_pkg::sat32(scl_r >>> FRAC_BITS);
    base_s  = npb_pkg::sat32(64'(acc_r[1]));
    fin_sat = sat_r | stdz_s[32] | base_s[32];
    for (int j = 0; j < npb_pkg::COMP_SLOTS; j++) begin
      bas_s[j] = '0;
      if (j < MAX_COMPONENTS) begin
        t = npb_pkg::sat32(64'(acc_r[2+j]));
        fin_sat = fin_sat | t[32];
        if (comp_r == 2'(j)) begin
          t = npb_pkg::sat32(64'($signed(t[31:0])) + 64'($signed(stdz_s[31:0])));
          fin_sat = fin_sat | t[32];
        end
        bas_s[j] = t;
      end
    end
    fin_w.row_out   = row_r;
    fin_w.step_last = end_r;
    if (bad_r) begin
      fin_w.standardized = '0;
      fin_w.baseline     = '0;
      fin_w.basis_0      = '0;
      fin_w.basis_1      = '0;
      fin_w.basis_2      = '0;
      fin_w.basis_3      = '0;
      fin_w.status       = npb_pkg::STS_CFG;
    end else begin
      fin_w.standardized = stdz_s[31:0];
      fin_w.baseline     = base_s[31:0];
      fin_w.basis_0      = bas_s[0][31:0];
      fin_w.basis_1      = bas_s[1][31:0];
      fin_w.basis_2      = bas_s[2][31:0];
      fin_w.basis_3      = bas_s[3][31:0];
      fin_w.status       = fin_sat ? npb_pkg::STS_SAT : npb_pkg::STS_OK;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      npb_pkg::ST_IDLE: begin
        if (in_valid && in_data.action == npb_pkg::ACT_ROW) begin
          state_nxt = cfg_bad ? npb_pkg::ST_FIN : npb_pkg::ST_MUL;
        end
      end
      npb_pkg::ST_MUL: begin
        if (cnt_r == 3'(npb_pkg::QTY_COUNT)) state_nxt = npb_pkg::ST_SCALE;
      end
      npb_pkg::ST_SCALE: state_nxt = npb_pkg::ST_FIN;
      npb_pkg::ST_FIN: begin
        if (!out_valid_r || !out_stall) state_nxt = npb_pkg::ST_IDLE;
      end
      default: state_nxt = npb_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall = 1'b1;
    fin_go   = 1'b0;
    unique case (state_r)
      npb_pkg::ST_IDLE:  in_stall = 1'b0;
      npb_pkg::ST_MUL:   in_stall = 1'b1;
      npb_pkg::ST_SCALE: in_stall = 1'b1;
      npb_pkg::ST_FIN:   fin_go   = !out_valid_r || !out_stall;
      default:           in_stall = 1'b1;
    endcase
    accept = in_valid && !in_stall;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= npb_pkg::ST_IDLE;
      state_size_r <= 4'd8;
      comp_count_r <= 3'd1;
      comp_ends_r  <= 16'd7;
      for (int j = 0; j < npb_pkg::COMP_SLOTS; j++) inv_r[j] <= 32'd65536;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          npb_pkg::REG_STATE_SIZE:  state_size_r <= cfg_data[3:0];
          npb_pkg::REG_COMP_COUNT:  comp_count_r <= cfg_data[2:0];
          npb_pkg::REG_COMP_ENDS:   comp_ends_r  <= cfg_data[15:0];
          npb_pkg::REG_INV_SCALE_0: inv_r[0]     <= cfg_data;
          npb_pkg::REG_INV_SCALE_1: inv_r[1]     <= cfg_data;
          npb_pkg::REG_INV_SCALE_2: inv_r[2]     <= cfg_data;
          npb_pkg::REG_INV_SCALE_3: inv_r[3]     <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // two banks, exchanged by flipping the select
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= 1'b0;
      for (int b = 0; b < 2; b++) begin
        for (int k = 0; k < MAX_STATE; k++) begin
          st_r[b][k] <= '0;
          bl_r[b][k] <= '0;
          for (int j = 0; j < MAX_COMPONENTS; j++) bs_r[b][k][j] <= '0;
        end
      end
    end else begin
      if (accept && in_data.action == npb_pkg::ACT_LOAD && 32'(in_data.row) < MAX_STATE) begin
        st_r[sel_r][RW'(in_data.row)] <= in_data.theta_value;
        bl_r[sel_r][RW'(in_data.row)] <= in_data.theta_value;
        for (int j = 0; j < MAX_COMPONENTS; j++) bs_r[sel_r][RW'(in_data.row)][j] <= '0;
      end
      if (fin_go && !bad_r) begin
        st_r[!sel_r][RW'(row_r)] <= theta_r;
        bl_r[!sel_r][RW'(row_r)] <= fin_w.baseline;
        for (int j = 0; j < MAX_COMPONENTS; j++) begin
          bs_r[!sel_r][RW'(row_r)][j] <= bas_s[j][31:0];
        end
      end
      if (fin_go && end_r) sel_r <= !sel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      if (fin_go) out_valid_r <= 1'b1;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == npb_pkg::ST_MUL) begin
        cnt_r <= cnt_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_data.action == npb_pkg::ACT_ROW) begin
      row_r   <= in_data.row;
      theta_r <= in_data.theta_value;
      end_r   <= in_data.step_end;
      bad_r   <= cfg_bad;
      comp_r  <= cfg_comp;
      g_r[0]  <= in_data.gain_0;
      g_r[1]  <= in_data.gain_1;
      g_r[2]  <= in_data.gain_2;
      g_r[3]  <= in_data.gain_3;
      g_r[4]  <= in_data.gain_4;
      g_r[5]  <= in_data.gain_5;
      g_r[6]  <= in_data.gain_6;
      g_r[7]  <= in_data.gain_7;
    end
    // lane sum lands in the cycle after its products
    if (state_r == npb_pkg::ST_MUL && cnt_r != 3'd0) begin
      acc_r[cnt_r - 3'd1] <= lane_sum;
    end
    if (state_r == npb_pkg::ST_SCALE) begin
      scl_r <= scl_nxt;
      sat_r <= innov_s[32];
    end
    if (fin_go) out_r <= fin_w;
  end

endmodule

FILE: design/npb_lane.sv
`timescale 1ns / 1ps
module npb_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [31:0]            gain,
  input  logic signed [31:0]            opnd,
  output logic signed [63-FRAC_BITS:0]  prod_r
);

  logic signed [63:0]           full;
  logic signed [63-FRAC_BITS:0] prod_nxt;

  always_comb begin
    full     = gain * opnd;
    // arithmetic shift floors toward minus infinity
    prod_nxt = en ? (64-FRAC_BITS)'(full >>> FRAC_BITS) : '0;
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

endmodule

FILE: design/npb_merge.sv
`timescale 1ns / 1ps
module npb_merge #(
  parameter int LANES     = 8,
  parameter int FRAC_BITS = 16
) (
  input  logic signed [63-FRAC_BITS:0] prod [LANES],
  output logic signed [66-FRAC_BITS:0] sum
);

  always_comb begin
    sum = '0;
    for (int k = 0; k < LANES; k++) begin
      sum = sum + (67-FRAC_BITS)'(prod[k]);
    end
  end

endmodule

FILE: design/npb_checker.sv
`timescale 1ns / 1ps
module npb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input npb_pkg::in_word_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input npb_pkg::out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result word changed while stalled");

  a_row_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.action == npb_pkg::ACT_ROW |=> in_stall)
    else $error("row word accepted without occupying the block");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status == npb_pkg::STS_OK || out_data.status == npb_pkg::STS_SAT
                  || out_data.status == npb_pkg::STS_CFG)
    else $error("undefined status code");

  a_cfg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status == npb_pkg::STS_CFG |->
      out_data.standardized == 0 && out_data.baseline == 0 && out_data.basis_0 == 0)
    else $error("configuration error word carries data");

endmodule

bind noncentered_path_basis npb_checker u_npb_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: sim/noncentered_path_basis_tb.sv
`timescale 1ns / 1ps
module noncentered_path_basis_tb;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  npb_pkg::in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  npb_pkg::out_word_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;

  noncentered_path_basis uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow of the block: configuration and both banks
  logic [3:0]  shadow_size;
  logic [2:0]  shadow_count;
  logic [15:0] shadow_ends;
  logic [31:0] shadow_scale [4];
  int prior_theta [8], prior_base [8], prior_comp [32];
  int fresh_theta [8], fresh_base [8], fresh_comp [32];

  npb_pkg::out_word_t row_results [$];
  int errors;
  int rows_seen;
  int sat_seen;
  int cfg_err_seen;
  int idle_cycles;
  bit quiet;

  function automatic int comp_of_row(input int r);
    int prev;
    int comp;
    int e;
    prev = -1;
    comp = -1;
    if (shadow_size < 1 || shadow_size > 8) return -1;
    if (shadow_count < 1 || shadow_count > 4) return -1;
    if (r >= shadow_size) return -1;
    for (int j = 0; j < shadow_count; j++) begin
      e = shadow_ends[4*j +: 4];
      if (e <= prev) return -1;
      if (comp < 0 && r <= e) comp = j;
      prev = e;
    end
    if (prev != shadow_size - 1) return -1;
    return comp;
  endfunction

  function automatic longint clamp32(input longint v, inout bit s);
    if (v > 64'sd2147483647) begin
      s = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      s = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic void swap_banks();
    int t;
    for (int i = 0; i < 8; i++) begin
      t = prior_theta[i]; prior_theta[i] = fresh_theta[i]; fresh_theta[i] = t;
      t = prior_base[i]; prior_base[i] = fresh_base[i]; fresh_base[i] = t;
    end
    for (int i = 0; i < 32; i++) begin
      t = prior_comp[i]; prior_comp[i] = fresh_comp[i]; fresh_comp[i] = t;
    end
  endfunction

  // advances the shadow by one word; returns 1 when a row result is due
  function automatic bit predict_row(input npb_pkg::in_word_t w,
                                     output npb_pkg::out_word_t o);
    longint g [8];
    longint acc_s, acc_b, innov, stdz, base;
    longint acc_c [4];
    longint basis [4];
    bit s;
    int comp, n, r;
    r = w.row;
    o = '0;
    if (w.action == npb_pkg::ACT_LOAD) begin
      prior_theta[r] = w.theta_value;
      prior_base[r] = w.theta_value;
      for (int j = 0; j < 4; j++) prior_comp[r*4+j] = 0;
      return 1'b0;
    end
    o.row_out = w.row;
    o.step_last = w.step_end;
    comp = comp_of_row(r);
    if (comp < 0) begin
      o.status = npb_pkg::STS_CFG;
      if (w.step_end) swap_banks();
      return 1'b1;
    end
    g = '{w.gain_0, w.gain_1, w.gain_2, w.gain_3, w.gain_4, w.gain_5, w.gain_6, w.gain_7};
    acc_s = 0;
    acc_b = 0;
    acc_c = '{0, 0, 0, 0};
    s = 1'b0;
    n = shadow_size;
    for (int k = 0; k < n; k++) begin
      acc_s += (g[k] * longint'(prior_theta[k])) >>> 16;
      acc_b += (g[k] * longint'(prior_base[k])) >>> 16;
      for (int j = 0; j < 4; j++) acc_c[j] += (g[k] * longint'(prior_comp[k*4+j])) >>> 16;
    end
    innov = clamp32(longint'(w.theta_value) - acc_s, s);
    stdz = clamp32((innov * longint'({32'd0, shadow_scale[comp]})) >>> 16, s);
    base = clamp32(acc_b, s);
    for (int j = 0; j < 4; j++) begin
      basis[j] = clamp32(acc_c[j], s);
      if (j == comp) basis[j] = clamp32(basis[j] + stdz, s);
    end
    fresh_theta[r] = w.theta_value;
    fresh_base[r] = int'(base);
    for (int j = 0; j < 4; j++) fresh_comp[r*4+j] = int'(basis[j]);
    o.standardized = stdz[31:0];
    o.baseline = base[31:0];
    o.basis_0 = basis[0][31:0];
    o.basis_1 = basis[1][31:0];
    o.basis_2 = basis[2][31:0];
    o.basis_3 = basis[3][31:0];
    o.status = s ? npb_pkg::STS_SAT : npb_pkg::STS_OK;
    if (w.step_end) swap_banks();
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      errors++;
      $display("%0t mismatch %s expected %0h actual %0h", $time, name, want, got);
    end
  endfunction

  // result side: random stall, compare each accepted word with the oldest prediction
  int stall_left;
  always @(posedge clk) begin
    npb_pkg::out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      idle_cycles = 0;
      if (row_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result word, expected none actual %0h", $time, out_data);
      end else begin
        want = row_results.pop_front();
        check_field("row_out", want.row_out, out_data.row_out);
        check_field("standardized", want.standardized, out_data.standardized);
        check_field("baseline", want.baseline, out_data.baseline);
        check_field("basis_0", want.basis_0, out_data.basis_0);
        check_field("basis_1", want.basis_1, out_data.basis_1);
        check_field("basis_2", want.basis_2, out_data.basis_2);
        check_field("basis_3", want.basis_3, out_data.basis_3);
        check_field("step_last", want.step_last, out_data.step_last);
        check_field("status", want.status, out_data.status);
        rows_seen++;
        if (want.status == npb_pkg::STS_SAT) sat_seen++;
        if (want.status == npb_pkg::STS_CFG) cfg_err_seen++;
      end
      stall_left = quiet ? 0 : $urandom_range(0, 4);
    end
    out_stall <= (stall_left > 0);
    if (stall_left > 0) stall_left--;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    idle_cycles++;
    if (idle_cycles >= 5000) begin
      $display("[noncentered_path_basis] ERROR");
      $finish;
    end
  end

  task automatic send_word(input npb_pkg::in_word_t w);
    int gap;
    npb_pkg::out_word_t o;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    idle_cycles = 0;
    if (predict_row(w, o)) row_results.push_back(o);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (row_results.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    idle_cycles = 0;
    cfg_valid <= 1'b0;
    case (idx)
      npb_pkg::REG_STATE_SIZE: shadow_size = val[3:0];
      npb_pkg::REG_COMP_COUNT: shadow_count = val[2:0];
      npb_pkg::REG_COMP_ENDS:  shadow_ends = val[15:0];
      default:                 shadow_scale[idx - npb_pkg::REG_INV_SCALE_0] = val;
    endcase
  endtask

  task automatic set_layout(input int sz, input int cnt, input logic [15:0] ends,
                            input logic [31:0] s0, input logic [31:0] s1,
                            input logic [31:0] s2, input logic [31:0] s3);
    drain();
    write_reg(npb_pkg::REG_STATE_SIZE, sz);
    write_reg(npb_pkg::REG_COMP_COUNT, cnt);
    write_reg(npb_pkg::REG_COMP_ENDS, ends);
    write_reg(npb_pkg::REG_INV_SCALE_0, s0);
    write_reg(npb_pkg::REG_INV_SCALE_1, s1);
    write_reg(npb_pkg::REG_INV_SCALE_2, s2);
    write_reg(npb_pkg::REG_INV_SCALE_3, s3);
  endtask

  function automatic logic [31:0] pick_value(input bit tame);
    case ($urandom_range(0, tame ? 5 : 3))
      0: return $urandom;
      1: return ($urandom_range(0, 3) == 0) ? 32'h7fffffff : 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h00010000 : 32'h00000000;
      default: return $urandom_range(0, 262143) - 131072;
    endcase
  endfunction

  function automatic npb_pkg::in_word_t make_word(input bit act, input int r, input bit last,
                                                  input bit tame);
    npb_pkg::in_word_t w;
    w.action = act;
    w.row = r;
    w.step_end = last;
    w.theta_value = pick_value(tame);
    w.gain_0 = pick_value(tame);
    w.gain_1 = pick_value(tame);
    w.gain_2 = pick_value(tame);
    w.gain_3 = pick_value(tame);
    w.gain_4 = pick_value(tame);
    w.gain_5 = pick_value(tame);
    w.gain_6 = pick_value(tame);
    w.gain_7 = pick_value(tame);
    return w;
  endfunction

  function automatic int path_rows();
    return (shadow_size >= 1 && shadow_size <= 8) ? shadow_size : 8;
  endfunction

  // one well-formed run: load the start state, then a few full steps
  task automatic run_path(input int steps);
    int sz;
    sz = path_rows();
    for (int r = 0; r < sz; r++) begin
      send_word(make_word(npb_pkg::ACT_LOAD, r, $urandom_range(0, 1), 1'b1));
    end
    for (int t = 0; t < steps; t++) begin
      for (int r = 0; r < sz; r++) begin
        send_word(make_word(npb_pkg::ACT_ROW, r, r == sz - 1, 1'b1));
      end
    end
  endtask

  task automatic test_directed();
    npb_pkg::in_word_t w;
    w = '0;
    w.action = npb_pkg::ACT_LOAD;
    w.row = 3'd7;
    w.theta_value = 32'h7fffffff;
    send_word(w);
    w.row = 3'd0;
    w.theta_value = 32'h80000000;
    send_word(w);
    // extreme gains against extreme state: saturates
    w = '0;
    w.action = npb_pkg::ACT_ROW;
    w.gain_0 = 32'h80000000;
    w.gain_7 = 32'h7fffffff;
    w.theta_value = 32'h7fffffff;
    send_word(w);
    w.row = 3'd7;
    w.gain_0 = 32'h7fffffff;
    w.step_end = 1'b1;
    send_word(w);
    send_word(make_word(npb_pkg::ACT_ROW, 2, 1'b1, 1'b0));
    // row beyond the state size and a bad layout both flag status
    set_layout(3, 1, 16'h0002, 32'h1, 32'h1, 32'h1, 32'h1);
    send_word(make_word(npb_pkg::ACT_ROW, 5, 1'b0, 1'b1));
    send_word(make_word(npb_pkg::ACT_ROW, 1, 1'b1, 1'b1));
    set_layout(8, 2, 16'h0077, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send_word(make_word(npb_pkg::ACT_ROW, 0, 1'b1, 1'b1));
    set_layout(0, 0, 16'h0000, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    send_word(make_word(npb_pkg::ACT_ROW, 0, 1'b0, 1'b1));
    set_layout(15, 7, 16'hffff, 32'h10000, 32'h10000, 32'h10000, 32'h10000);
    send_word(make_word(npb_pkg::ACT_ROW, 7, 1'b1, 1'b1));
    set_layout(8, 4, 16'h7531, 32'hffffffff, 32'h1, 32'h8000, 32'h30000);
    run_path(1);
  endtask

  task automatic test_random(input int budget);
    int sent;
    int steps;
    sent = 0;
    while (sent < budget) begin
      quiet = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 5))
        0: set_layout(8, 4, 16'h7531, $urandom, $urandom, $urandom, $urandom);
        1: set_layout(8, 1, 16'h0007, $urandom_range(1, 200000), 1, 1, 1);
        2: set_layout(1, 1, 16'h0000, 32'hffffffff, 1, 1, 1);
        3: set_layout(5, 3, 16'h0431, $urandom_range(1, 200000), $urandom, 32'h10000,
                      32'h1);
        4: set_layout($urandom_range(0, 15), $urandom_range(0, 7), $urandom,
                      $urandom, $urandom, $urandom, $urandom);
        default: ;
      endcase
      if ($urandom_range(0, 3) == 0) begin
        for (int i = 0; i < 12; i++) begin
          send_word(make_word($urandom_range(0, 1), $urandom_range(0, 7),
                              $urandom_range(0, 1), 1'b0));
        end
        sent += 12;
      end else begin
        steps = $urandom_range(1, 4);
        sent += path_rows() * (steps + 1);
        run_path(steps);
      end
      if ($urandom_range(0, 9) == 0) begin
        in_valid <= 1'b0;
        while (row_results.size() != 0) @(posedge clk);
      end
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    out_stall <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= npb_pkg::REG_STATE_SIZE;
    cfg_data <= '0;
    errors = 0;
    rows_seen = 0;
    sat_seen = 0;
    cfg_err_seen = 0;
    idle_cycles = 0;
    stall_left = 0;
    quiet = 1'b0;
    shadow_size = 4'd8;
    shadow_count = 3'd1;
    shadow_ends = 16'd7;
    shadow_scale = '{32'h10000, 32'h10000, 32'h10000, 32'h10000};
    for (int i = 0; i < 8; i++) begin
      prior_theta[i] = 0; prior_base[i] = 0; fresh_theta[i] = 0; fresh_base[i] = 0;
    end
    for (int i = 0; i < 32; i++) begin
      prior_comp[i] = 0; fresh_comp[i] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(1530);
    drain();
    $display("covered %0d row results, %0d saturated, %0d with bad layout,",
             rows_seen, sat_seen, cfg_err_seen);
    $display("over loads, full steps, bank swaps and random layouts under stalls");
    if (errors == 0) begin
      $display("[noncentered_path_basis] OK");
    end else begin
      $display("[noncentered_path_basis] ERROR");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/npb_pkg.sv
design/npb_lane.sv
design/npb_merge.sv
design/noncentered_path_basis.sv
design/npb_checker.sv
sim/noncentered_path_basis_tb.sv
